>>> rtl/vndce_pkg.sv
package vndce_pkg;

  localparam int unsigned BUF_MAX = 2048;
  localparam int unsigned HDR_LEN = 12;
  localparam int unsigned BT_W = 12;
  localparam int unsigned HOP_W = 16;
  localparam logic [HOP_W-1:0] RING_SIZE_RESET = 16'd256;

  typedef enum logic [1:0] {
    OP_TX_GATHER  = 2'd0,
    OP_RX_CAP     = 2'd1,
    OP_RX_SCATTER = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_FETCH = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        first_of_chain;
    logic        is_writable;
    logic        has_next;
    logic [14:0] next_index;
    logic [31:0] desc_length;
    logic [63:0] desc_address;
    logic        access_error;
    logic [10:0] frame_length;
  } desc_t;

  typedef struct packed {
    status_t     status;
    logic [14:0] fetch_index;
    logic [63:0] chunk_address;
    logic [11:0] chunk_offset;
    logic [11:0] chunk_length;
    logic [10:0] frame_room;
    logic [11:0] used_length;
    logic [11:0] work_bytes;
  } result_t;

endpackage

>>> rtl/vndce_in_stage.sv
module vndce_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vndce_pkg::desc_t  in_desc,
  input  logic              take,
  output logic              desc_valid,
  output vndce_pkg::desc_t  desc
);

  logic             valid_r;
  logic             valid_nxt;
  vndce_pkg::desc_t desc_r;

  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      desc_r <= in_desc;
    end
  end

  assign desc_valid = valid_r;
  assign desc       = desc_r;

endmodule

>>> rtl/vndce_walk.sv
module vndce_walk (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  vndce_pkg::desc_t   desc,
  input  logic               cfg_write_en,
  input  logic [15:0]        cfg_write_data,
  output vndce_pkg::result_t result
);

  localparam int unsigned BtW  = vndce_pkg::BT_W;
  localparam int unsigned HopW = vndce_pkg::HOP_W;
  localparam logic [BtW-1:0] BufMax = BtW'(vndce_pkg::BUF_MAX);
  localparam logic [BtW-1:0] HdrLen = BtW'(vndce_pkg::HDR_LEN);

  logic [HopW-1:0] ring_size_r;
  logic [BtW-1:0]  byte_total_r, byte_total_nxt;
  logic [HopW-1:0] hop_count_r, hop_count_nxt;
  logic            chain_failed_r, chain_failed_nxt;
  logic [BtW-1:0]  scatter_target_r, scatter_target_nxt;

  logic [BtW-1:0]  bt_cur;
  logic [HopW-1:0] hop_cur;
  logic [BtW-1:0]  tgt_cur;
  logic            closed;
  logic [BtW-1:0]  room;
  logic [HopW:0]   hop_inc;
  logic            hop_bad;
  logic            len_bad;
  logic [BtW-1:0]  take_len;
  logic [BtW-1:0]  sum;
  logic [BtW-1:0]  tgt_first;
  logic [BtW-1:0]  tgt_use;
  logic [BtW-1:0]  left;
  logic            fail;
  vndce_pkg::result_t res;

  always_comb begin
    bt_cur   = desc.first_of_chain ? '0 : byte_total_r;
    hop_cur  = desc.first_of_chain ? '0 : hop_count_r;
    tgt_cur  = desc.first_of_chain ? '0 : scatter_target_r;
    closed   = !desc.first_of_chain && chain_failed_r;
    room     = BufMax - bt_cur;
    hop_inc  = {1'b0, hop_cur} + (HopW+1)'(1);
    hop_bad  = hop_inc > {1'b0, ring_size_r};
    len_bad  = desc.desc_length > {20'd0, room};
    tgt_first = HdrLen + {1'b0, desc.frame_length};
    if (tgt_first > BufMax) begin
      tgt_first = BufMax;
    end
    tgt_use  = desc.first_of_chain ? tgt_first : scatter_target_r;
    left     = tgt_use - bt_cur;
    take_len = '0;
    sum      = bt_cur;

    byte_total_nxt     = bt_cur;
    hop_count_nxt      = hop_cur;
    scatter_target_nxt = tgt_cur;
    chain_failed_nxt   = closed;
    fail               = 1'b0;
    res                = '0;
    res.status         = vndce_pkg::ST_FETCH;

    if (closed) begin
      fail = 1'b1;
    end else begin
      case (vndce_pkg::opcode_t'(desc.opcode))
        vndce_pkg::OP_TX_GATHER: begin
          sum = bt_cur + desc.desc_length[BtW-1:0];
          if (desc.is_writable || desc.access_error || len_bad) begin
            fail = 1'b1;
          end else begin
            byte_total_nxt = sum;
            if (!desc.has_next) begin
              if (sum < HdrLen) begin
                fail = 1'b1;
              end else begin
                chain_failed_nxt  = 1'b1;
                res.status        = vndce_pkg::ST_DONE;
                res.chunk_address = desc.desc_address;
                res.chunk_offset  = bt_cur;
                res.chunk_length  = desc.desc_length[BtW-1:0];
                res.work_bytes    = sum;
              end
            end else if (hop_bad) begin
              fail = 1'b1;
            end else begin
              hop_count_nxt     = hop_inc[HopW-1:0];
              res.fetch_index   = desc.next_index;
              res.chunk_address = desc.desc_address;
              res.chunk_offset  = bt_cur;
              res.chunk_length  = desc.desc_length[BtW-1:0];
            end
          end
        end
        vndce_pkg::OP_RX_CAP: begin
          take_len = (desc.desc_length < {20'd0, room}) ? desc.desc_length[BtW-1:0] : room;
          sum      = bt_cur + take_len;
          if (!desc.is_writable || desc.access_error) begin
            fail = 1'b1;
          end else begin
            byte_total_nxt = sum;
            if (!desc.has_next) begin
              if (sum < HdrLen) begin
                fail = 1'b1;
              end else begin
                chain_failed_nxt = 1'b1;
                res.status       = vndce_pkg::ST_DONE;
                res.frame_room   = 11'(sum - HdrLen);
              end
            end else if (hop_bad) begin
              fail = 1'b1;
            end else begin
              hop_count_nxt   = hop_inc[HopW-1:0];
              res.fetch_index = desc.next_index;
            end
          end
        end
        vndce_pkg::OP_RX_SCATTER: begin
          take_len = (desc.desc_length < {20'd0, left}) ? desc.desc_length[BtW-1:0] : left;
          sum      = bt_cur + take_len;
          if (desc.access_error) begin
            fail = 1'b1;
          end else if (desc.first_of_chain && desc.frame_length == '0) begin
            chain_failed_nxt = 1'b1;
            res.status       = vndce_pkg::ST_EMPTY;
          end else if (bt_cur > tgt_use) begin
            fail = 1'b1;
          end else begin
            scatter_target_nxt = tgt_use;
            byte_total_nxt     = sum;
            if (sum >= tgt_use) begin
              chain_failed_nxt  = 1'b1;
              res.status        = vndce_pkg::ST_DONE;
              res.chunk_address = desc.desc_address;
              res.chunk_offset  = bt_cur;
              res.chunk_length  = take_len;
              res.used_length   = tgt_use;
              res.work_bytes    = (tgt_use >= HdrLen) ? tgt_use - HdrLen : '0;
            end else if (!desc.has_next || hop_bad) begin
              fail = 1'b1;
            end else begin
              hop_count_nxt     = hop_inc[HopW-1:0];
              res.fetch_index   = desc.next_index;
              res.chunk_address = desc.desc_address;
              res.chunk_offset  = bt_cur;
              res.chunk_length  = take_len;
            end
          end
        end
        default: begin
          fail = 1'b1;
        end
      endcase
    end

    if (fail) begin
      chain_failed_nxt = 1'b1;
      res              = '0;
      res.status       = vndce_pkg::ST_ERROR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_size_r      <= vndce_pkg::RING_SIZE_RESET;
      byte_total_r     <= '0;
      hop_count_r      <= '0;
      chain_failed_r   <= 1'b0;
      scatter_target_r <= '0;
    end else begin
      if (cfg_write_en) begin
        ring_size_r <= cfg_write_data;
      end
      if (step_en) begin
        byte_total_r     <= byte_total_nxt;
        hop_count_r      <= hop_count_nxt;
        chain_failed_r   <= chain_failed_nxt;
        scatter_target_r <= scatter_target_nxt;
      end
    end
  end

  assign result = res;

endmodule

>>> rtl/vndce_out_stage.sv
module vndce_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  input  vndce_pkg::result_t res,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output vndce_pkg::result_t out_res
);

  logic               valid_r;
  logic               valid_nxt;
  vndce_pkg::result_t res_r;

  assign take = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

>>> rtl/virtio_net_descriptor_chain_engine.sv
// Path: a transferred descriptor is held in the input register, walked combinationally, and
// its result is captured in the result register.
// Throughput: one descriptor per cycle; while a result waits one more descriptor is held,
// then the input stalls until the result transfer.
// Reset: synchronous, active low; clears chain state and sets ring_size to 256.
module virtio_net_descriptor_chain_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic        in_first_of_chain,
  input  logic        in_is_writable,
  input  logic        in_has_next,
  input  logic [14:0] in_next_index,
  input  logic [31:0] in_desc_length,
  input  logic [63:0] in_desc_address,
  input  logic        in_access_error,
  input  logic [10:0] in_frame_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [14:0] out_fetch_index,
  output logic [63:0] out_chunk_address,
  output logic [11:0] out_chunk_offset,
  output logic [11:0] out_chunk_length,
  output logic [10:0] out_frame_room,
  output logic [11:0] out_used_length,
  output logic [11:0] out_work_bytes,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data
);

  vndce_pkg::desc_t   in_desc;
  vndce_pkg::desc_t   desc;
  logic               desc_valid;
  logic               take;
  logic               step_en;
  vndce_pkg::result_t walk_res;
  vndce_pkg::result_t out_res;

  assign in_desc.opcode         = in_opcode;
  assign in_desc.first_of_chain = in_first_of_chain;
  assign in_desc.is_writable    = in_is_writable;
  assign in_desc.has_next       = in_has_next;
  assign in_desc.next_index     = in_next_index;
  assign in_desc.desc_length    = in_desc_length;
  assign in_desc.desc_address   = in_desc_address;
  assign in_desc.access_error   = in_access_error;
  assign in_desc.frame_length   = in_frame_length;

  assign step_en = desc_valid && take;

  vndce_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_desc    (in_desc),
    .take       (take),
    .desc_valid (desc_valid),
    .desc       (desc)
  );

  vndce_walk u_walk (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (step_en),
    .desc           (desc),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .result         (walk_res)
  );

  vndce_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (desc_valid),
    .res       (walk_res),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_status        = out_res.status;
  assign out_fetch_index   = out_res.fetch_index;
  assign out_chunk_address = out_res.chunk_address;
  assign out_chunk_offset  = out_res.chunk_offset;
  assign out_chunk_length  = out_res.chunk_length;
  assign out_frame_room    = out_res.frame_room;
  assign out_used_length   = out_res.used_length;
  assign out_work_bytes    = out_res.work_bytes;

  a_step_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_valid)
    else $error("transfer from input register did not reach result register");

  a_stall_holds_desc: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> desc_valid && !take)
    else $error("input stalled without a held descriptor");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == vndce_pkg::ST_ERROR |->
      out_fetch_index == '0 && out_chunk_address == '0 && out_chunk_length == '0 &&
      out_used_length == '0 && out_work_bytes == '0 && out_frame_room == '0)
    else $error("error result carries nonzero fields");

  a_chunk_in_buffer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_chunk_offset} + {1'b0, out_chunk_length}) <=
      13'(vndce_pkg::BUF_MAX))
    else $error("chunk runs past staging buffer");

endmodule
